@@ design/box_mean_filter_3x3_rgb_defines.svh @@
// Assertion macros shared by the box mean filter.
`ifndef BOX_MEAN_FILTER_3X3_RGB_DEFINES_SVH
`define BOX_MEAN_FILTER_3X3_RGB_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define BMF_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When the trigger holds, the consequence must hold once the delay given by n has passed.
`define BMF_ASSERT_AFTER(label, clk, rst, trig, n, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> ##n (cons)) \
      else $error(msg);

`endif

@@ design/bmf_pkg.sv @@
package bmf_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int ADDR_W      = $clog2(MAX_WIDTH);
   localparam int WIDTH_W     = 11;
   localparam int HEIGHT_W    = 16;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 1;
   localparam int POS_W       = (ADDR_W + 1 > WIDTH_W) ? ADDR_W + 1 : WIDTH_W;
   localparam int TOT_W       = POS_W + HEIGHT_W;
   localparam int ROW_W       = HEIGHT_W + 1;

   localparam int CHAN_W      = 8;
   localparam int COLSUM_W    = 10;
   localparam int SUM_W       = 12;
   localparam int RECIP_W     = 13;
   localparam int RECIP_SHIFT = 16;
   localparam int PROD_W      = SUM_W + RECIP_W;

   localparam int FIFO_DEPTH  = 8;
   localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W  = FIFO_PTR_W + 1;
   localparam int CREDIT_W    = FIFO_CNT_W + 1;
   localparam int PEND_W      = 2;

   typedef logic [ADDR_W-1:0]     addr_type;
   typedef logic [POS_W-1:0]      pos_type;
   typedef logic [HEIGHT_W-1:0]   height_type;
   typedef logic [TOT_W-1:0]      total_type;
   typedef logic [ROW_W-1:0]      row_type;
   typedef logic [FIFO_CNT_W-1:0] fifo_cnt_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = CSR_INDEX_W'(1);

   localparam pos_type    RST_WIDTH  = pos_type'(640);
   localparam height_type RST_HEIGHT = height_type'(480);
   localparam total_type  RST_TOTAL  = total_type'(640 * 480);

   // Nine times this reciprocal is two over a power of two, which keeps the floor exact
   // for every channel sum below 32768.
   localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'(7282);

   typedef struct packed {
      logic [CHAN_W-1:0] r;
      logic [CHAN_W-1:0] g;
      logic [CHAN_W-1:0] b;
   } pix_type;

   typedef struct packed {
      pix_type upper;
      pix_type middle;
   } rows_type;

   typedef struct packed {
      logic [COLSUM_W-1:0] r;
      logic [COLSUM_W-1:0] g;
      logic [COLSUM_W-1:0] b;
   } colsum_type;

   typedef struct packed {
      logic [CHAN_W-1:0] r;
      logic [CHAN_W-1:0] g;
      logic [CHAN_W-1:0] b;
      logic              done;
   } result_type;

endpackage

@@ design/bmf_line_store.sv @@
module bmf_line_store (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  bmf_pkg::addr_type rd_addr,
   input  logic              wr_en,
   input  bmf_pkg::addr_type wr_addr,
   input  bmf_pkg::rows_type wr_data,
   output bmf_pkg::rows_type rd_data
);

   bmf_pkg::rows_type rows_mem_ff [bmf_pkg::MAX_WIDTH];
   bmf_pkg::rows_type rd_data_ff;
   bmf_pkg::rows_type fwd_data_ff;
   logic              fwd_ff;
   logic              fwd_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rows_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff  <= rows_mem_ff[rd_addr];
         fwd_data_ff <= wr_data;
      end
   end

   // A read that meets a write to the same entry at the same edge takes the new data.
   always_comb begin
      fwd_in = fwd_ff;
      if (rd_en) begin
         fwd_in = wr_en && (rd_addr == wr_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else begin
         fwd_ff <= fwd_in;
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : rd_data_ff;

endmodule

@@ design/bmf_col_cell.sv @@
module bmf_col_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                shift_en,
   input  logic                skip,
   input  bmf_pkg::colsum_type feed_sum,
   output bmf_pkg::colsum_type held_sum,
   output bmf_pkg::colsum_type contrib
);

   bmf_pkg::colsum_type sum_ff;
   bmf_pkg::colsum_type sum_in;

   always_comb begin
      sum_in = shift_en ? feed_sum : sum_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   assign held_sum = sum_ff;
   assign contrib  = skip ? '0 : sum_ff;

endmodule

@@ design/bmf_out_fifo.sv @@
module bmf_out_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  bmf_pkg::result_type   push_data,
   input  logic                  out_stall,
   output logic                  out_valid,
   output bmf_pkg::result_type   out_data,
   output bmf_pkg::fifo_cnt_type count
);

   bmf_pkg::result_type           entries_ff [bmf_pkg::FIFO_DEPTH];
   logic [bmf_pkg::FIFO_PTR_W-1:0] wr_ptr_ff;
   logic [bmf_pkg::FIFO_PTR_W-1:0] wr_ptr_in;
   logic [bmf_pkg::FIFO_PTR_W-1:0] rd_ptr_ff;
   logic [bmf_pkg::FIFO_PTR_W-1:0] rd_ptr_in;
   bmf_pkg::fifo_cnt_type          count_ff;
   bmf_pkg::fifo_cnt_type          count_in;
   logic                           pop;

   always_comb begin
      pop       = (count_ff != '0) && !out_stall;
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + bmf_pkg::fifo_cnt_type'(push) - bmf_pkg::fifo_cnt_type'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign out_valid = count_ff != '0;
   assign out_data  = entries_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

@@ design/box_mean_filter_3x3_rgb.sv @@
// A result passes the stage registers p1, p2 and p3 into the output queue after the item that completes its window,
// which is the item one row and one pixel after the centre pixel.
// Throughput: one item per clock when not stalled, set by the single read and single write port of the line store.
// Synchronous active-high reset sets the frame to 640 by 480 and clears counters, window and queue.
// The line store is not cleared; rows above the image are masked to zero on read.
`include "box_mean_filter_3x3_rgb_defines.svh"

module box_mean_filter_3x3_rgb (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_is_fill,
   input  logic [bmf_pkg::CHAN_W-1:0]          req_red_in,
   input  logic [bmf_pkg::CHAN_W-1:0]          req_green_in,
   input  logic [bmf_pkg::CHAN_W-1:0]          req_blue_in,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [bmf_pkg::CHAN_W-1:0]          rsp_red_mean,
   output logic [bmf_pkg::CHAN_W-1:0]          rsp_green_mean,
   output logic [bmf_pkg::CHAN_W-1:0]          rsp_blue_mean,
   output logic                                rsp_frame_done,
   input  logic                                csr_wr_en,
   input  logic [bmf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [bmf_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   typedef struct packed {
      logic has_out;
      logic skip_l;
      logic skip_r;
      logic done;
   } stage_ctl_type;

   typedef struct packed {
      logic [bmf_pkg::SUM_W-1:0] r;
      logic [bmf_pkg::SUM_W-1:0] g;
      logic [bmf_pkg::SUM_W-1:0] b;
   } sum_type;

   function automatic logic [bmf_pkg::CHAN_W-1:0] mean9(input logic [bmf_pkg::SUM_W-1:0] s);
      logic [bmf_pkg::PROD_W-1:0] prod;
      prod  = bmf_pkg::PROD_W'(s) * bmf_pkg::PROD_W'(bmf_pkg::RECIP_9);
      mean9 = prod[bmf_pkg::RECIP_SHIFT +: bmf_pkg::CHAN_W];
   endfunction

   // Frame geometry.
   bmf_pkg::pos_type    w_ff, w_in;
   bmf_pkg::height_type h_ff, h_in;
   bmf_pkg::total_type  total_ff, total_in;
   logic [bmf_pkg::WIDTH_W-1:0] raw_w;
   bmf_pkg::pos_type    eff_w;
   bmf_pkg::height_type eff_h;
   bmf_pkg::pos_type    mul_a;
   bmf_pkg::height_type mul_b;

   // Position counters.
   bmf_pkg::addr_type  col_ff, col_in;
   bmf_pkg::row_type   row_ff, row_in;
   bmf_pkg::total_type em_ff, em_in;
   bmf_pkg::addr_type  base_col;
   bmf_pkg::row_type   base_row;
   bmf_pkg::total_type base_em;
   bmf_pkg::total_type em_next;
   bmf_pkg::pos_type   col_next;
   logic               restart;
   logic               wrap;
   logic               blank;
   logic               ready;
   logic               done_now;
   logic               acc;
   bmf_pkg::pix_type   pix;
   stage_ctl_type      ctl_now;

   // Stage registers.
   logic                 p1_valid_ff, p2_valid_ff, p3_valid_ff;
   stage_ctl_type        p1_ctl_ff, p2_ctl_ff, p3_ctl_ff;
   bmf_pkg::pix_type     p1_pix_ff;
   bmf_pkg::addr_type    p1_col_ff;
   logic                 p1_up_en_ff;
   logic                 p1_mid_en_ff;
   sum_type              p3_sum_ff;
   sum_type              p2_sum;

   bmf_pkg::rows_type    store_rd;
   bmf_pkg::rows_type    store_wr;
   bmf_pkg::pix_type     up_px;
   bmf_pkg::pix_type     mid_px;
   bmf_pkg::colsum_type  new_col;
   bmf_pkg::colsum_type  held2, held1, held0;
   bmf_pkg::colsum_type  part2, part1, part0;

   bmf_pkg::result_type   push_data;
   logic                  push;
   bmf_pkg::result_type   out_data;
   bmf_pkg::fifo_cnt_type fifo_count;
   logic [bmf_pkg::PEND_W-1:0]   pending;
   logic [bmf_pkg::CREDIT_W-1:0] credit_used;

   // Configuration writes; the frame size product is formed as the register is written.
   always_comb begin
      raw_w = csr_wdata[bmf_pkg::WIDTH_W-1:0];
      if (raw_w == '0) begin
         eff_w = bmf_pkg::pos_type'(1);
      end else if (bmf_pkg::pos_type'(raw_w) > bmf_pkg::pos_type'(bmf_pkg::MAX_WIDTH)) begin
         eff_w = bmf_pkg::pos_type'(bmf_pkg::MAX_WIDTH);
      end else begin
         eff_w = bmf_pkg::pos_type'(raw_w);
      end
      eff_h = (csr_wdata[bmf_pkg::HEIGHT_W-1:0] == '0) ?
              bmf_pkg::height_type'(1) : csr_wdata[bmf_pkg::HEIGHT_W-1:0];
      w_in  = w_ff;
      h_in  = h_ff;
      mul_a = w_ff;
      mul_b = h_ff;
      case (csr_index)
         bmf_pkg::CSR_IMAGE_WIDTH: begin
            mul_a = eff_w;
            if (csr_wr_en) begin
               w_in = eff_w;
            end
         end
         bmf_pkg::CSR_IMAGE_HEIGHT: begin
            mul_b = eff_h;
            if (csr_wr_en) begin
               h_in = eff_h;
            end
         end
         default: begin
            mul_a = w_ff;
         end
      endcase
      total_in = csr_wr_en ?
                 bmf_pkg::total_type'(mul_a) * bmf_pkg::total_type'(mul_b) : total_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff     <= bmf_pkg::RST_WIDTH;
         h_ff     <= bmf_pkg::RST_HEIGHT;
         total_ff <= bmf_pkg::RST_TOTAL;
      end else begin
         w_ff     <= w_in;
         h_ff     <= h_in;
         total_ff <= total_in;
      end
   end

   // Position of the incoming item and what it causes.
   always_comb begin
      acc      = req_valid && !req_stall;
      restart  = em_ff >= total_ff;
      base_col = (restart || bmf_pkg::pos_type'(col_ff) >= w_ff) ? '0 : col_ff;
      base_row = restart ? '0 : row_ff;
      base_em  = restart ? '0 : em_ff;
      blank    = req_is_fill || (base_row >= bmf_pkg::row_type'(h_ff));
      pix      = blank ? '0 :
                 bmf_pkg::pix_type'{r: req_red_in, g: req_green_in, b: req_blue_in};
      ready    = (base_row >= bmf_pkg::row_type'(2)) ||
                 ((base_row == bmf_pkg::row_type'(1)) && (base_col != '0));
      col_next = bmf_pkg::pos_type'(base_col) + bmf_pkg::pos_type'(1);
      wrap     = col_next >= w_ff;
      em_next  = base_em + bmf_pkg::total_type'(ready);
      done_now = ready && (em_next >= total_ff);

      // The centre lies one column back; the first column has no left neighbor and the
      // last column no right neighbor.
      ctl_now.has_out = ready;
      ctl_now.skip_l  = (base_col == bmf_pkg::addr_type'(1)) || (w_ff == bmf_pkg::pos_type'(1));
      ctl_now.skip_r  = base_col == '0;
      ctl_now.done    = done_now;

      col_in = col_ff;
      row_in = row_ff;
      em_in  = em_ff;
      if (acc) begin
         if (done_now) begin
            col_in = '0;
            row_in = '0;
            em_in  = '0;
         end else begin
            col_in = wrap ? '0 : col_next[bmf_pkg::ADDR_W-1:0];
            row_in = (wrap && (base_row != '1)) ? base_row + 1'b1 : base_row;
            em_in  = em_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         em_ff  <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         em_ff  <= em_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         p1_pix_ff    <= pix;
         p1_col_ff    <= base_col;
         p1_up_en_ff  <= base_row >= bmf_pkg::row_type'(2);
         p1_mid_en_ff <= base_row != '0;
         p1_ctl_ff    <= ctl_now;
      end
      p2_ctl_ff <= p1_ctl_ff;
      p3_ctl_ff <= p2_ctl_ff;
      p3_sum_ff <= p2_sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= acc;
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= p2_valid_ff;
      end
   end

   // Line store: the upper row takes the old middle row, the middle row the new pixel.
   always_comb begin
      up_px          = p1_up_en_ff ? store_rd.upper : '0;
      mid_px         = p1_mid_en_ff ? store_rd.middle : '0;
      store_wr       = '{upper: mid_px, middle: p1_pix_ff};
      new_col.r      = bmf_pkg::COLSUM_W'(up_px.r) + bmf_pkg::COLSUM_W'(mid_px.r) +
                       bmf_pkg::COLSUM_W'(p1_pix_ff.r);
      new_col.g      = bmf_pkg::COLSUM_W'(up_px.g) + bmf_pkg::COLSUM_W'(mid_px.g) +
                       bmf_pkg::COLSUM_W'(p1_pix_ff.g);
      new_col.b      = bmf_pkg::COLSUM_W'(up_px.b) + bmf_pkg::COLSUM_W'(mid_px.b) +
                       bmf_pkg::COLSUM_W'(p1_pix_ff.b);
   end

   bmf_line_store u_line_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (acc),
      .rd_addr (base_col),
      .wr_en   (p1_valid_ff),
      .wr_addr (p1_col_ff),
      .wr_data (store_wr),
      .rd_data (store_rd)
   );

   // Window: three column cells, newest first.
   bmf_col_cell u_cell_new (
      .clock    (clock),
      .reset    (reset),
      .shift_en (p1_valid_ff),
      .skip     (p2_ctl_ff.skip_r),
      .feed_sum (new_col),
      .held_sum (held2),
      .contrib  (part2)
   );

   bmf_col_cell u_cell_mid (
      .clock    (clock),
      .reset    (reset),
      .shift_en (p1_valid_ff),
      .skip     (1'b0),
      .feed_sum (held2),
      .held_sum (held1),
      .contrib  (part1)
   );

   bmf_col_cell u_cell_old (
      .clock    (clock),
      .reset    (reset),
      .shift_en (p1_valid_ff),
      .skip     (p2_ctl_ff.skip_l),
      .feed_sum (held1),
      .held_sum (held0),
      .contrib  (part0)
   );

   always_comb begin
      p2_sum.r = bmf_pkg::SUM_W'(part0.r) + bmf_pkg::SUM_W'(part1.r) + bmf_pkg::SUM_W'(part2.r);
      p2_sum.g = bmf_pkg::SUM_W'(part0.g) + bmf_pkg::SUM_W'(part1.g) + bmf_pkg::SUM_W'(part2.g);
      p2_sum.b = bmf_pkg::SUM_W'(part0.b) + bmf_pkg::SUM_W'(part1.b) + bmf_pkg::SUM_W'(part2.b);
      push_data.r    = mean9(p3_sum_ff.r);
      push_data.g    = mean9(p3_sum_ff.g);
      push_data.b    = mean9(p3_sum_ff.b);
      push_data.done = p3_ctl_ff.done;
      push           = p3_valid_ff && p3_ctl_ff.has_out;
      // Results still in the pipeline hold a place in the output queue.
      pending        = bmf_pkg::PEND_W'(p1_valid_ff && p1_ctl_ff.has_out) +
                       bmf_pkg::PEND_W'(p2_valid_ff && p2_ctl_ff.has_out) +
                       bmf_pkg::PEND_W'(push);
      credit_used    = bmf_pkg::CREDIT_W'(fifo_count) + bmf_pkg::CREDIT_W'(pending);
      req_stall      = credit_used >= bmf_pkg::CREDIT_W'(bmf_pkg::FIFO_DEPTH);
   end

   bmf_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .out_data  (out_data),
      .count     (fifo_count)
   );

   assign rsp_red_mean   = out_data.r;
   assign rsp_green_mean = out_data.g;
   assign rsp_blue_mean  = out_data.b;
   assign rsp_frame_done = out_data.done;

   `BMF_ASSERT_ALWAYS(a_queue_credit, clock, reset, credit_used <= bmf_pkg::CREDIT_W'(bmf_pkg::FIFO_DEPTH), "output queue overbooked")
   `BMF_ASSERT_AFTER(a_result_reaches_queue, clock, reset, acc && ready, 3, push, "result did not reach the output queue")

endmodule

@@ bench/tb.sv @@
module tb;
   import bmf_pkg::*;

   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned SETTLE_CYCLES = 12;
   localparam int unsigned HOLD_CYCLES = 200;

   typedef struct packed {
      logic    fill;
      pix_type px;
   } stream_item_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_is_fill = 1'b0;
   logic [CHAN_W-1:0]      req_red_in = '0;
   logic [CHAN_W-1:0]      req_green_in = '0;
   logic [CHAN_W-1:0]      req_blue_in = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [CHAN_W-1:0]      rsp_red_mean;
   logic [CHAN_W-1:0]      rsp_green_mean;
   logic [CHAN_W-1:0]      rsp_blue_mean;
   logic                   rsp_frame_done;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   stream_item_type pixel_queue[$];
   result_type      mean_queue[$];

   // Shadow copy of the filter state.
   logic [WIDTH_W-1:0]  cfg_width = 11'd640;
   logic [HEIGHT_W-1:0] cfg_height = 16'd480;
   pix_type             upper_line [MAX_WIDTH];
   pix_type             middle_line [MAX_WIDTH];
   pix_type             win [3][3];
   int unsigned         col_pos = 0;
   int unsigned         row_pos = 0;
   int unsigned         emitted = 0;

   int unsigned sender_idle_pct = 0;
   int unsigned receiver_idle_pct = 0;
   bit          hold_request = 1'b0;
   bit          hold_started = 1'b0;
   int unsigned hold_left = 0;
   int unsigned quiet_cycles = 0;
   int unsigned items_taken = 0;
   int unsigned means_checked = 0;
   int unsigned frames_done = 0;
   int unsigned mean_errors = 0;

   box_mean_filter_3x3_rgb u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_is_fill   (req_is_fill),
      .req_red_in    (req_red_in),
      .req_green_in  (req_green_in),
      .req_blue_in   (req_blue_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_red_mean  (rsp_red_mean),
      .rsp_green_mean(rsp_green_mean),
      .rsp_blue_mean (rsp_blue_mean),
      .rsp_frame_done(rsp_frame_done),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic int unsigned eff_width(logic [WIDTH_W-1:0] w);
      if (w == 0) return 1;
      if (w > MAX_WIDTH) return MAX_WIDTH;
      return 32'(w);
   endfunction

   function automatic int unsigned eff_height(logic [HEIGHT_W-1:0] h);
      return (h == 0) ? 1 : 32'(h);
   endfunction

   function automatic result_type window_mean(bit skip_left, bit skip_right);
      int unsigned sr;
      int unsigned sg;
      int unsigned sb;
      result_type  res;
      sr = 0;
      sg = 0;
      sb = 0;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if (!((c == 0 && skip_left) || (c == 2 && skip_right))) begin
               sr += win[r][c].r;
               sg += win[r][c].g;
               sb += win[r][c].b;
            end
         end
      end
      res.r = CHAN_W'(sr / 9);
      res.g = CHAN_W'(sg / 9);
      res.b = CHAN_W'(sb / 9);
      res.done = 1'b0;
      return res;
   endfunction

   task automatic restart_shadow_frame();
      col_pos = 0;
      row_pos = 0;
      emitted = 0;
   endtask

   // One accepted item: shift the line stores and the window, and queue the
   // mean of the pixel one row and one column back once its window is complete.
   task automatic advance_filter(input logic fill, input pix_type px);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned cx;
      pix_type     p;
      pix_type     up;
      pix_type     mid;
      bit          ready;
      result_type  res;
      w = eff_width(cfg_width);
      h = eff_height(cfg_height);
      if (col_pos >= w) col_pos = 0;
      if (emitted >= w * h) restart_shadow_frame();
      c = col_pos;
      p = (fill || row_pos >= h) ? pix_type'('0) : px;
      up = (row_pos >= 2) ? upper_line[c] : pix_type'('0);
      mid = (row_pos >= 1) ? middle_line[c] : pix_type'('0);
      upper_line[c] = mid;
      middle_line[c] = p;
      for (int r = 0; r < 3; r++) begin
         win[r][0] = win[r][1];
         win[r][1] = win[r][2];
      end
      win[0][2] = up;
      win[1][2] = mid;
      win[2][2] = p;
      ready = (row_pos >= 2) || (row_pos == 1 && c >= 1);
      col_pos = c + 1;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      if (ready) begin
         cx = (c == 0) ? w - 1 : c - 1;
         res = window_mean(cx == 0, cx == w - 1);
         emitted++;
         if (emitted >= w * h) begin
            res.done = 1'b1;
            restart_shadow_frame();
         end
         mean_queue.push_back(res);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            advance_filter(pixel_queue[0].fill, pixel_queue[0].px);
            void'(pixel_queue.pop_front());
            items_taken++;
         end
         if (!(req_valid && req_stall)) begin
            if (pixel_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               req_valid <= 1'b1;
               req_is_fill <= pixel_queue[0].fill;
               req_red_in <= pixel_queue[0].px.r;
               req_green_in <= pixel_queue[0].px.g;
               req_blue_in <= pixel_queue[0].px.b;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      result_type exp;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (mean_queue.size() == 0) begin
               $error("Result with no item waiting for it: red %0d green %0d blue %0d done %0d",
                  rsp_red_mean, rsp_green_mean, rsp_blue_mean, rsp_frame_done);
               mean_errors++;
            end else begin
               exp = mean_queue.pop_front();
               means_checked++;
               if (exp.done) frames_done++;
               if (rsp_red_mean !== exp.r) begin
                  $error("red_mean: expected %0d, actual %0d", exp.r, rsp_red_mean);
                  mean_errors++;
               end
               if (rsp_green_mean !== exp.g) begin
                  $error("green_mean: expected %0d, actual %0d", exp.g, rsp_green_mean);
                  mean_errors++;
               end
               if (rsp_blue_mean !== exp.b) begin
                  $error("blue_mean: expected %0d, actual %0d", exp.b, rsp_blue_mean);
                  mean_errors++;
               end
               if (rsp_frame_done !== exp.done) begin
                  $error("frame_done: expected %0d, actual %0d", exp.done, rsp_frame_done);
                  mean_errors++;
               end
            end
         end
         if (hold_request && !hold_started) begin
            hold_started = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles.", STALL_LIMIT);
            $display("[box_mean_filter_3x3_rgb] ERROR");
            $finish;
         end
      end
   end

   function automatic logic [CHAN_W-1:0] random_channel();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return CHAN_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic stream_item_type random_item(int unsigned fill_pct);
      stream_item_type it;
      it.fill = ($urandom_range(0, 99) < fill_pct);
      it.px.r = random_channel();
      it.px.g = random_channel();
      it.px.b = random_channel();
      return it;
   endfunction

   task automatic drain_pipeline();
      do @(negedge clock);
      while (pixel_queue.size() != 0 || req_valid || mean_queue.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_frame_size(input int unsigned w, input int unsigned h);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wdata <= CSR_DATA_W'(w);
      cfg_width = WIDTH_W'(w);
      @(posedge clock);
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_wdata <= CSR_DATA_W'(h);
      cfg_height = HEIGHT_W'(h);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // A full frame of pixels followed by one row and one pixel of flush items.
   task automatic queue_frame();
      int unsigned w;
      int unsigned h;
      w = eff_width(cfg_width);
      h = eff_height(cfg_height);
      for (int unsigned i = 0; i < w * h; i++) pixel_queue.push_back(random_item(12));
      for (int unsigned i = 0; i <= w; i++) pixel_queue.push_back(random_item(75));
   endtask

   // Feeds one item at a time until the shadow counters are back at a frame start.
   task automatic complete_frame();
      while (col_pos != 0 || row_pos != 0 || emitted != 0) begin
         pixel_queue.push_back(random_item(50));
         drain_pipeline();
      end
   endtask

   task automatic random_phase(input int unsigned target);
      int unsigned start;
      start = items_taken + pixel_queue.size();
      while (items_taken + pixel_queue.size() < start + target) begin
         if ($urandom_range(0, 1) == 0) begin
            drain_pipeline();
            if ($urandom_range(0, 7) == 0) begin
               set_frame_size($urandom_range(11, 48), $urandom_range(0, 6));
            end else begin
               set_frame_size($urandom_range(0, 10), $urandom_range(0, 6));
            end
         end
         queue_frame();
         if ($urandom_range(0, 5) == 0) drain_pipeline();
      end
   endtask

   initial begin
      stream_item_type it;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) win[r][c] = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      sender_idle_pct = 18;
      receiver_idle_pct = 71;

      // Zero width and zero height both act as one.
      set_frame_size(0, 0);
      it = '{fill: 1'b0, px: '{r: 8'hFF, g: 8'hFF, b: 8'hFF}};
      pixel_queue.push_back(it);
      it = '{fill: 1'b1, px: '{r: 8'hFF, g: 8'h00, b: 8'hAA}};
      pixel_queue.push_back(it);
      pixel_queue.push_back(it);
      drain_pipeline();

      // Saturated and alternating pixels with a fill item inside the frame.
      set_frame_size(3, 2);
      it = '{fill: 1'b0, px: '{r: 8'hFF, g: 8'hFF, b: 8'hFF}};
      repeat (2) pixel_queue.push_back(it);
      it = '{fill: 1'b0, px: '{r: 8'hAA, g: 8'h55, b: 8'h00}};
      pixel_queue.push_back(it);
      it = '{fill: 1'b1, px: '{r: 8'hFF, g: 8'hFF, b: 8'hFF}};
      pixel_queue.push_back(it);
      it = '{fill: 1'b0, px: '{r: 8'h55, g: 8'hAA, b: 8'hFF}};
      repeat (2) pixel_queue.push_back(it);
      it = '{fill: 1'b1, px: '{r: 8'h00, g: 8'h00, b: 8'h00}};
      repeat (4) pixel_queue.push_back(it);
      drain_pipeline();

      // Real pixels offered after the last pixel of the frame count as zero.
      set_frame_size(2, 1);
      it = '{fill: 1'b0, px: '{r: 8'hFF, g: 8'hFF, b: 8'hFF}};
      repeat (5) pixel_queue.push_back(it);
      drain_pipeline();

      // Shrinking the height mid-frame below the emitted count restarts the frame.
      set_frame_size(1, 65535);
      repeat (10) pixel_queue.push_back(random_item(0));
      drain_pipeline();
      set_frame_size(1, 5);
      complete_frame();

      // Shrinking the width mid-frame wraps the column position.
      set_frame_size(8, 4);
      repeat (13) pixel_queue.push_back(random_item(10));
      drain_pipeline();
      set_frame_size(3, 4);
      complete_frame();

      random_phase(90);

      drain_pipeline();
      sender_idle_pct = 71;
      receiver_idle_pct = 18;
      random_phase(90);

      drain_pipeline();
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      set_frame_size(16, 8);
      queue_frame();
      hold_request = 1'b1;
      drain_pipeline();

      // An oversized width acts as the largest row; the frame is cut short by a new size.
      set_frame_size(2047, 1);
      repeat (12) pixel_queue.push_back(random_item(20));
      drain_pipeline();
      set_frame_size(3, 2);
      complete_frame();
      random_phase(90);

      drain_pipeline();
      $display("Fed %0d items and checked %0d means over %0d completed frames,",
         items_taken, means_checked, frames_done);
      $display("with widths from 1 to 48, an oversized width, tall frames and mid-frame changes.");
      if (mean_errors == 0 && mean_queue.size() == 0) begin
         $display("[box_mean_filter_3x3_rgb] OK");
      end else begin
         $display("[box_mean_filter_3x3_rgb] ERROR");
      end
      $finish;
   end
endmodule
